[hdl/rlbd_pkg.sv]
// Shared types and constants for the resistor ladder button decoder.
`default_nettype none

package rlbd_pkg;

	// Field widths
	localparam int ADC_W      = 10;
	localparam int COUNT_W    = 16;
	localparam int HOLD_W     = 16;
	localparam int DEBOUNCE_W = 8;
	localparam int ACTIVE_W   = 3;

	// Register file geometry
	localparam int MAX_BUTTONS = 4;
	localparam int LEVELS_W    = MAX_BUTTONS * ADC_W;
	localparam int HOLDS_W     = MAX_BUTTONS * HOLD_W;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;

	// Stream widths (padded to whole bytes)
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 8;

	// Parameter defaults
	localparam int DEF_NUM_BUTTONS      = 4;
	localparam int DEF_SAMPLE_PERIOD_MS = 20;

	// Top of the ADC range
	localparam logic [ADC_W-1:0] ADC_TOP = '1;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MARGIN      = 3'd0,
		REG_DEBOUNCE    = 3'd1,
		REG_ACTIVE      = 3'd2,
		REG_LEVELS      = 3'd3,
		REG_HOLD_TIMES  = 3'd4
	} cfg_reg_t;

	// Per-button result of one sample
	typedef struct packed {
		logic stop;   // held button released: later buttons skipped
		logic click;
		logic hold;
	} slot_stat_t;

endpackage

`default_nettype wire

[hdl/resistor_ladder_button_decoder.sv]
// Resistor ladder keypad decoder: top level with stream ports and registers.
//
// Usage: one 10-bit ADC sample of the ladder voltage enters per item on the
// s_ channel (s_tdata[9:0]). Each sample yields exactly one result item on the
// m_ channel: click mask in m_tdata[3:0], hold mask in m_tdata[7:4], bit i for
// button i; both masks are zero when nothing fires.
// Registers are written over the cfg_ channel (index, 64-bit data); cfg_ready
// is always high. Write them only while no sample is in flight.
// A sample passes the input register, then the result register, before its
// result is on m_tdata. Throughput: one item per cycle while the receiver
// takes results; the button state updates in one pass per sample, so
// consecutive samples follow without gaps.
// When the receiver stalls, the result register holds and the input register
// fills; s_tready drops only when both are occupied, and rises again in the
// cycle the result is taken.
// Reset (arst_n low) clears all registers, press counts, held marks and
// both pipeline slots.
`default_nettype none

module resistor_ladder_button_decoder #(
	parameter int NUM_BUTTONS      = rlbd_pkg::DEF_NUM_BUTTONS,
	parameter int SAMPLE_PERIOD_MS = rlbd_pkg::DEF_SAMPLE_PERIOD_MS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Sample items
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [rlbd_pkg::S_DATA_W-1:0]     s_tdata,  // [9:0] sample
	// Result items
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [rlbd_pkg::M_DATA_W-1:0]          m_tdata,  // [3:0] click_mask, [7:4] hold_mask
	// Register writes
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [rlbd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [rlbd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import rlbd_pkg::*;

	// Registers
	logic [ADC_W-1:0]      margin_q;
	logic [DEBOUNCE_W-1:0] debounce_q;
	logic [ACTIVE_W-1:0]   active_q;
	logic [LEVELS_W-1:0]   levels_q;
	logic [HOLDS_W-1:0]    holds_q;

	// Pipeline
	logic                  valid_s1;
	logic [ADC_W-1:0]      sample_s1;
	logic                  advance;
	logic                  out_valid_q;
	logic [M_DATA_W-1:0]   out_data_q;

	// Per-button signals
	slot_stat_t            stat   [NUM_BUTTONS];
	logic [MAX_BUTTONS-1:0] check;
	logic [MAX_BUTTONS-1:0] click_vec;
	logic [MAX_BUTTONS-1:0] hold_vec;

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q   <= '0;
			debounce_q <= '0;
			active_q   <= '0;
			levels_q   <= '0;
			holds_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MARGIN:     margin_q   <= cfg_data[ADC_W-1:0];
				REG_DEBOUNCE:   debounce_q <= cfg_data[DEBOUNCE_W-1:0];
				REG_ACTIVE:     active_q   <= cfg_data[ACTIVE_W-1:0];
				REG_LEVELS:     levels_q   <= cfg_data[LEVELS_W-1:0];
				REG_HOLD_TIMES: holds_q    <= cfg_data[HOLDS_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= s_tdata[ADC_W-1:0];
		end
	end

	// Button slots, checked in order; a released held button stops the chain
	for (genvar gi = 0; gi < MAX_BUTTONS; gi++) begin : g_btn
		if (gi < NUM_BUTTONS) begin : g_on
			if (gi == 0) begin : g_first
				assign check[gi] = active_q > ACTIVE_W'(gi);
			end else begin : g_next
				assign check[gi] = check[gi-1] && !stat[gi-1].stop &&
					(active_q > ACTIVE_W'(gi));
			end

			rlbd_slot #(
				.SAMPLE_PERIOD_MS(SAMPLE_PERIOD_MS)
			) u_slot (
				.clk            (clk),
				.arst_n         (arst_n),
				.advance        (advance),
				.check          (check[gi]),
				.sample         (sample_s1),
				.level          (levels_q[gi*ADC_W +: ADC_W]),
				.margin         (margin_q),
				.debounce_count (debounce_q),
				.hold_time      (holds_q[gi*HOLD_W +: HOLD_W]),
				.stat           (stat[gi])
			);

			assign click_vec[gi] = stat[gi].click;
			assign hold_vec[gi]  = stat[gi].hold;
		end else begin : g_off
			assign check[gi]     = 1'b0;
			assign click_vec[gi] = 1'b0;
			assign hold_vec[gi]  = 1'b0;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {hold_vec, click_vec};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Checks
	a_click_hold_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[3:0] & m_tdata[7:4]) == 4'd0))
		else $error("click and hold on the same button");

	a_unused_bits: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (((m_tdata[3:0] | m_tdata[7:4]) >> NUM_BUTTONS) == 4'd0))
		else $error("event on a button beyond NUM_BUTTONS");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("result lost after advance");

endmodule

`default_nettype wire

[hdl/rlbd_slot.sv]
// One button: window compare, press counter, held mark and event decision.
`default_nettype none

module rlbd_slot #(
	parameter int SAMPLE_PERIOD_MS = rlbd_pkg::DEF_SAMPLE_PERIOD_MS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              advance,
	input  wire logic                              check,
	input  wire logic [rlbd_pkg::ADC_W-1:0]        sample,
	input  wire logic [rlbd_pkg::ADC_W-1:0]        level,
	input  wire logic [rlbd_pkg::ADC_W-1:0]        margin,
	input  wire logic [rlbd_pkg::DEBOUNCE_W-1:0]   debounce_count,
	input  wire logic [rlbd_pkg::HOLD_W-1:0]       hold_time,
	output rlbd_pkg::slot_stat_t                   stat
);
	import rlbd_pkg::*;

	localparam int PERIOD_W = $clog2(SAMPLE_PERIOD_MS + 1);
	localparam int PROD_W   = COUNT_W + PERIOD_W;

	logic [COUNT_W-1:0] count_q;
	logic               held_q;

	logic [ADC_W-1:0]   win_lo;
	logic [ADC_W:0]     hi_sum;
	logic [ADC_W-1:0]   win_hi;
	logic               in_win;
	logic [COUNT_W-1:0] count_inc;
	logic [PROD_W-1:0]  elapsed;
	logic               hold_hit;
	logic [COUNT_W-1:0] count_d;
	logic               held_d;

	// Acceptance window, clamped to the ADC range
	always_comb begin
		win_lo = (level <= margin) ? '0 : level - margin;
		hi_sum = {1'b0, level} + {1'b0, margin};
		win_hi = hi_sum[ADC_W] ? ADC_TOP : hi_sum[ADC_W-1:0];
		in_win = (sample >= win_lo) && (sample <= win_hi);
	end

	// Saturating count and elapsed time in ms
	always_comb begin
		count_inc = (&count_q) ? count_q : count_q + COUNT_W'(1);
		elapsed   = PROD_W'(count_inc) * PROD_W'(SAMPLE_PERIOD_MS);
		hold_hit  = elapsed >= PROD_W'(hold_time);
	end

	// Next state and events
	always_comb begin
		count_d    = count_q;
		held_d     = held_q;
		stat       = '0;
		if (check) begin
			if (in_win) begin
				if (hold_hit) begin
					count_d   = '0;
					held_d    = 1'b1;
					stat.hold = 1'b1;
				end else begin
					count_d = count_inc;
				end
			end else if (held_q) begin
				held_d    = 1'b0;
				count_d   = '0;
				stat.stop = 1'b1;
			end else if (count_q != '0) begin
				stat.click = count_q >= COUNT_W'(debounce_count);
				count_d    = '0;
			end
		end
	end

	// Button state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			held_q  <= 1'b0;
		end else if (advance && check) begin
			count_q <= count_d;
			held_q  <= held_d;
		end
	end

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the resistor ladder button decoder.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rlbd_pkg::*;

	localparam int NUM_BTN     = DEF_NUM_BUTTONS;
	localparam int PERIOD_MS   = DEF_SAMPLE_PERIOD_MS;
	localparam int CYCLE_LIMIT = 600000;

	// Click and hold masks of one result item
	typedef struct packed {
		logic [3:0] hold;
		logic [3:0] click;
	} keypad_evt_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_DATA_W-1:0]    s_tdata = '0;   // [9:0] sample
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_DATA_W-1:0]    m_tdata;        // [3:0] click_mask, [7:4] hold_mask
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	resistor_ladder_button_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Decoder copy: registers and per-button state
	logic [9:0]  cfg_margin = '0;
	logic [7:0]  cfg_debounce = '0;
	logic [2:0]  cfg_active = '0;
	logic [39:0] cfg_levels = '0;
	logic [63:0] cfg_holds = '0;
	logic [15:0] press_cnt [4];
	logic        held_flag [4];

	keypad_evt_t pending_events [$];
	int          mismatch_cnt = 0;
	int          cycle_cnt = 0;
	bit          no_idle = 1'b0;
	int          hold_off_req = 0;
	int          stall_left = 0;

	always #10 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Idle length: mostly short, a few long
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Window bounds of one button under the current margin
	function automatic void window_of(int b, output int lo, output int hi);
		int lv;
		lv = int'(cfg_levels[10*b +: 10]);
		lo = (lv <= int'(cfg_margin)) ? 0 : lv - int'(cfg_margin);
		hi = lv + int'(cfg_margin);
		if (hi > int'(ADC_TOP))
			hi = int'(ADC_TOP);
	endfunction

	// Advance the button state by one sample and return the events it fires
	function automatic keypad_evt_t decode_sample(logic [9:0] smp);
		keypad_evt_t ev;
		int n, lo, hi, c;
		ev = '0;
		n = (cfg_active > NUM_BTN) ? NUM_BTN : int'(cfg_active);
		for (int i = 0; i < n; i++) begin
			window_of(i, lo, hi);
			if (int'(smp) >= lo && int'(smp) <= hi) begin
				c = int'(press_cnt[i]);
				if (c < 65535)
					c++;
				press_cnt[i] = c[15:0];
				if (c * PERIOD_MS >= int'(cfg_holds[16*i +: 16])) begin
					ev.hold[i] = 1'b1;
					press_cnt[i] = '0;
					held_flag[i] = 1'b1;
				end
			end else begin
				// leaving the window after a hold ends this sample's scan
				if (held_flag[i]) begin
					held_flag[i] = 1'b0;
					press_cnt[i] = '0;
					break;
				end
				if (press_cnt[i] != 0) begin
					if (press_cnt[i] >= 16'(cfg_debounce))
						ev.click[i] = 1'b1;
					press_cnt[i] = '0;
				end
			end
		end
		return ev;
	endfunction

	task automatic report_mismatch(input string what, input logic [3:0] got,
			input logic [3:0] want);
		$display("mismatch at cycle %0d: %s got %b want %b", cycle_cnt, what, got, want);
		mismatch_cnt++;
	endtask

	// Result side: check each item, then pick the next ready value
	always @(posedge clk) begin
		keypad_evt_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				report_mismatch("unexpected item, click", m_tdata[3:0], 4'b0);
			end else begin
				want = pending_events.pop_front();
				if (m_tdata[3:0] !== want.click)
					report_mismatch("click_mask", m_tdata[3:0], want.click);
				if (m_tdata[7:4] !== want.hold)
					report_mismatch("hold_mask", m_tdata[7:4], want.hold);
			end
		end
		if (hold_off_req != 0) begin
			stall_left = hold_off_req;
			hold_off_req = 0;
		end
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (!no_idle && $urandom_range(0, 99) < 25) begin
			stall_left = idle_len() - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Offer one sample; predict its events once accepted
	task automatic send_sample(input logic [9:0] smp);
		int gap;
		gap = (no_idle || $urandom_range(0, 99) < 55) ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_DATA_W-ADC_W){1'b0}}, smp};
		do @(posedge clk); while (!s_tready);
		pending_events.push_back(decode_sample(smp));
	endtask

	// Stop offering and wait until every result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MARGIN:     cfg_margin = val[9:0];
			REG_DEBOUNCE:   cfg_debounce = val[7:0];
			REG_ACTIVE:     cfg_active = val[2:0];
			REG_LEVELS:     cfg_levels = val[39:0];
			REG_HOLD_TIMES: cfg_holds = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [9:0] mrg, input logic [7:0] deb,
			input logic [2:0] act, input logic [39:0] lvls, input logic [63:0] hlds);
		drain();
		write_reg(REG_MARGIN, {54'b0, mrg});
		write_reg(REG_DEBOUNCE, {56'b0, deb});
		write_reg(REG_ACTIVE, {61'b0, act});
		write_reg(REG_LEVELS, {24'b0, lvls});
		write_reg(REG_HOLD_TIMES, hlds);
		cfg_valid <= 1'b0;
	endtask

	// Register defaults: no button active, so nothing fires
	task automatic test_after_reset();
		send_sample(10'd0);
		send_sample(10'd1023);
		send_sample(10'd0);
	endtask

	// Four buttons covering the bottom clamp, zero hold, release after hold
	task automatic test_directed_windows();
		set_config(10'd10, 8'd3, 3'd4,
			{10'd1000, 10'd300, 10'd700, 10'd0},
			{16'd100, 16'd65535, 16'd60, 16'd0});
		send_sample(10'd0);      // zero hold time fires
		send_sample(10'd0);      // and again
		send_sample(10'd300);    // held button 0 leaves, scan stops
		send_sample(10'd290);
		send_sample(10'd310);
		send_sample(10'd1023);   // button 2 leaves below debounce: no click
		send_sample(10'd1010);
		send_sample(10'd990);
		send_sample(10'd1023);
		send_sample(10'd1000);   // button 3 pressed again, short of its hold time
		send_sample(10'd700);    // button 3 released below debounce, press on button 1
		send_sample(10'd700);
		send_sample(10'd710);    // hold on button 1
		send_sample(10'd5);      // button 1 release after hold stops the scan
		send_sample(10'd300);
		send_sample(10'd289);    // sample just below button 2's window: no click
		send_sample(10'd311);
		send_sample(10'd512);
	endtask

	// Full-range windows, large active count, maximum debounce
	task automatic test_wide_windows();
		set_config(10'd1023, 8'd255, 3'd7,
			{10'd1023, 10'd0, 10'd512, 10'd341},
			{16'd40, 16'd0, 16'hFFFF, 16'd20});
		send_sample(10'd0);
		send_sample(10'd1023);
		send_sample(10'd511);
		send_sample(10'd682);
	endtask

	// Zero-width window, zero debounce, single button
	task automatic test_narrow_window();
		set_config(10'd0, 8'd0, 3'd1, {30'b0, 10'd512}, {48'b0, 16'hFFFF});
		send_sample(10'd512);
		send_sample(10'd511);
		send_sample(10'd512);
		send_sample(10'd512);
		send_sample(10'd513);
	endtask

	function automatic logic [9:0] window_sample(int b);
		int lo, hi;
		window_of(b, lo, hi);
		return 10'($urandom_range(lo, hi));
	endfunction

	task automatic random_config();
		logic [9:0]  mrg;
		logic [7:0]  deb;
		logic [2:0]  act;
		logic [63:0] hlds;
		int          r;
		r = $urandom_range(0, 99);
		mrg = (r < 10) ? 10'd0 : (r < 20) ? 10'd1023 : 10'($urandom_range(0, 40));
		r = $urandom_range(0, 99);
		deb = (r < 10) ? 8'd255 : (r < 25) ? 8'd0 : 8'($urandom_range(1, 8));
		r = $urandom_range(0, 99);
		act = (r < 10) ? 3'($urandom_range(5, 7)) : (r < 15) ? 3'd0 :
			3'($urandom_range(1, 4));
		for (int i = 0; i < 4; i++) begin
			r = $urandom_range(0, 99);
			hlds[16*i +: 16] = (r < 15) ? 16'd0 : (r < 30) ? 16'($urandom_range(0, 65535)) :
				16'(PERIOD_MS * $urandom_range(1, 15) + $urandom_range(0, PERIOD_MS - 1));
		end
		set_config(mrg, deb, act, 40'({$urandom, $urandom}), hlds);
	endtask

	// Press/release sequences with random content, plus noise samples
	task automatic test_random_phase(input int n_items);
		int sent, n_btn, b, len, r;
		sent = 0;
		while (sent < n_items) begin
			n_btn = (cfg_active > NUM_BTN) ? NUM_BTN : int'(cfg_active);
			if (n_btn == 0 || $urandom_range(0, 99) < 15) begin
				send_sample(10'($urandom_range(0, 1023)));
				sent++;
			end else begin
				b = $urandom_range(0, n_btn - 1);
				r = $urandom_range(0, 99);
				len = (r < 3) ? $urandom_range(250, 300) :
					(r < 12) ? $urandom_range(20, 80) : $urandom_range(1, 12);
				repeat (len) send_sample(window_sample(b));
				send_sample(10'($urandom_range(0, 1023)));
				sent += len + 1;
			end
		end
	endtask

	// Receiver holds off while samples keep coming: input must stall
	task automatic test_backpressure();
		no_idle = 1'b1;
		hold_off_req = 300;
		repeat (40) send_sample(10'($urandom_range(0, 1023)));
		no_idle = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < 4; i++) begin
			press_cnt[i] = '0;
			held_flag[i] = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_directed_windows();
		test_wide_windows();
		test_narrow_window();
		for (int ph = 0; ph < 6; ph++) begin
			random_config();
			no_idle = (ph == 3);
			test_random_phase(155);
			no_idle = 1'b0;
		end
		random_config();
		test_backpressure();

		drain();
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
